// File: design/tsfp_pkg.sv
// Package for the distance sensor frame parser.
// Holds frame layout constants and the queue item types; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tsfp_pkg;

    localparam int MAX_LEN_DEF = 30;
    localparam int FRAME_BYTES = 27;
    localparam int SUM_BYTES   = 26;
    localparam int LEN_W       = 5;

    localparam logic [7:0] HDR_BYTE0 = 8'h5A;
    localparam logic [7:0] HDR_BYTE1 = 8'h8E;
    localparam logic [7:0] HDR_BYTE2 = 8'h17;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_END  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_q_head;

endpackage

`default_nettype wire

// File: design/tsfp_front.sv
// Front end of the frame parser: accepts items, classifies them as data byte
// or end of frame, and holds them in a two-entry queue. Uses tsfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsfp_front
    import tsfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_mode,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_pop,
    output t_q_head         o_head
);

    t_op        r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       push;
    t_op        n_op;

    assign o_ready = (r_fill != 2'd2);
    assign push    = i_valid && o_ready;

    always_comb begin
        n_op.kind = i_mode ? KIND_END : KIND_BYTE;
        n_op.data = i_rx_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_op;
        end
    end

    assign o_head.valid = (r_fill != 2'd0);
    assign o_head.op    = r_q[r_rd_ptr];

endmodule

`default_nettype wire

// File: design/tsfp_back.sv
// Back end of the frame parser: byte count, running sum, positional capture,
// frame checks, wrapping counters and the result register. Uses tsfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsfp_back
    import tsfp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_q_head         i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic                 o_frame_ok,
    output logic [LEN_W-1:0]     o_frame_length,
    output logic                 o_overflow,
    output logic signed [15:0]   o_cal_distance_mm,
    output logic [7:0]           o_confidence,
    output logic [15:0]          o_meas_tof,
    output logic [15:0]          o_meas_peak,
    output logic [23:0]          o_meas_noise,
    output logic [15:0]          o_ref_tof,
    output logic signed [31:0]   o_temperature_centi,
    output logic [31:0]          o_good_frames,
    output logic [31:0]          o_bad_frames
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_sum;
    logic             r_ovf;
    logic [31:0]      r_good;
    logic [31:0]      r_bad;
    logic [7:0]       r_store [FRAME_BYTES];
    logic             r_out_valid;

    logic             out_free;
    logic             take_byte;
    logic             take_end;
    logic             emit;
    logic             ok;
    logic [31:0]      n_good;
    logic [31:0]      n_bad;

    assign out_free  = !r_out_valid || i_ready;
    assign o_pop     = i_head.valid && (i_head.op.kind == KIND_BYTE || out_free);
    assign take_byte = o_pop && (i_head.op.kind == KIND_BYTE);
    assign take_end  = o_pop && (i_head.op.kind == KIND_END);
    assign emit      = take_end && (r_count != '0);

    assign ok = !r_ovf && (r_count == CNT_W'(FRAME_BYTES))
             && (r_store[0] == HDR_BYTE0) && (r_store[1] == HDR_BYTE1)
             && (r_store[2] == HDR_BYTE2) && (r_store[SUM_BYTES] == r_sum);

    assign n_good = ok ? r_good + 32'd1 : r_good;
    assign n_bad  = ok ? r_bad : r_bad + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= 8'd0;
            r_ovf       <= 1'b0;
            r_good      <= 32'd0;
            r_bad       <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (take_byte) begin
                if (r_count < CNT_W'(MAX_LEN)) begin
                    if (r_count < CNT_W'(SUM_BYTES)) begin
                        r_sum <= r_sum + i_head.op.data;
                    end
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (emit) begin
                r_count     <= '0;
                r_sum       <= 8'd0;
                r_ovf       <= 1'b0;
                r_good      <= n_good;
                r_bad       <= n_bad;
                r_out_valid <= 1'b1;
            end
        end
    end

    // positional capture of the bytes that the checks and fields use
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < FRAME_BYTES; k++) begin
            if (take_byte && (r_count == CNT_W'(k))) begin
                r_store[k] <= i_head.op.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_frame_ok     <= ok;
            o_frame_length <= r_count[LEN_W-1:0];
            o_overflow     <= r_ovf;
            o_good_frames  <= n_good;
            o_bad_frames   <= n_bad;
            if (ok) begin
                o_cal_distance_mm   <= {r_store[24], r_store[23]};
                o_confidence        <= r_store[25];
                o_meas_tof          <= {r_store[4], r_store[3]};
                o_meas_peak         <= {r_store[6], r_store[5]};
                o_meas_noise        <= {r_store[9], r_store[8], r_store[7]};
                o_ref_tof           <= {r_store[18], r_store[17]};
                o_temperature_centi <= {r_store[22], r_store[21], r_store[20], r_store[19]};
            end else begin
                o_cal_distance_mm   <= 16'sd0;
                o_confidence        <= 8'd0;
                o_meas_tof          <= 16'd0;
                o_meas_peak         <= 16'd0;
                o_meas_noise        <= 24'd0;
                o_ref_tof           <= 16'd0;
                o_temperature_centi <= 32'sd0;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// File: design/tof_sensor_frame_parser_top.sv
// Distance sensor frame parser, top level.
// Instantiates tsfp_front and tsfp_back; uses tsfp_pkg.
//
// Input channel (i_valid/o_ready): one item per handshake, either a received
// byte (i_mode 0, i_rx_byte) or an idle-line event (i_mode 1) ending a frame.
// Output channel (o_valid/i_ready): one result per idle event that closes a
// frame holding at least one byte; an idle event on an empty frame yields none.
// Throughput: one item per cycle while the queue is not full. Each item is
// written into the input queue first; the back end updates frame state in
// the cycle it pops it; a popped idle item sets o_valid and the result fields.
// A stalled receiver holds the result register; bytes keep flowing into the
// frame state, and an idle item waits at the head of the two-entry queue
// until the result register frees. o_ready drops only when that queue fills.
// Reset (i_rst_n low, synchronous) empties the queue, clears byte count, sum,
// overflow mark and both frame counters, and drops o_valid. Bytes past
// MAX_LEN are dropped and flag overflow for that frame.
`timescale 1ns / 1ps
`default_nettype none

module tof_sensor_frame_parser_top
    import tsfp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_mode,
    input  wire logic [7:0]         i_rx_byte,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_frame_ok,
    output logic [LEN_W-1:0]        o_frame_length,
    output logic                    o_overflow,
    output logic signed [15:0]      o_cal_distance_mm,
    output logic [7:0]              o_confidence,
    output logic [15:0]             o_meas_tof,
    output logic [15:0]             o_meas_peak,
    output logic [23:0]             o_meas_noise,
    output logic [15:0]             o_ref_tof,
    output logic signed [31:0]      o_temperature_centi,
    output logic [31:0]             o_good_frames,
    output logic [31:0]             o_bad_frames
);

    t_q_head head;
    logic    pop;

    tsfp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_mode    (i_mode),
        .i_rx_byte (i_rx_byte),
        .i_pop     (pop),
        .o_head    (head)
    );

    tsfp_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_head              (head),
        .o_pop               (pop),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_frame_ok          (o_frame_ok),
        .o_frame_length      (o_frame_length),
        .o_overflow          (o_overflow),
        .o_cal_distance_mm   (o_cal_distance_mm),
        .o_confidence        (o_confidence),
        .o_meas_tof          (o_meas_tof),
        .o_meas_peak         (o_meas_peak),
        .o_meas_noise        (o_meas_noise),
        .o_ref_tof           (o_ref_tof),
        .o_temperature_centi (o_temperature_centi),
        .o_good_frames       (o_good_frames),
        .o_bad_frames        (o_bad_frames)
    );

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

    a_ok_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_ok) |-> (o_frame_length == LEN_W'(FRAME_BYTES)) && !o_overflow)
        else $error("good frame with wrong length or overflow");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_ok) |-> (o_temperature_centi == 32'sd0)
            && (o_cal_distance_mm == 16'sd0) && (o_meas_noise == 24'd0))
        else $error("bad frame carries field data");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
